/* hw/rtl/htr_pkg.sv */
`timescale 1ns / 1ps

package htr_pkg;

    // Default ring depth; the ring holds one entry fewer than this
    localparam int SLOTS_DEFAULT = 128;

    // Byte limit after reset
    localparam logic [31:0] RESET_LIMIT = 32'd4096;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ADDED     = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_FULL      = 2'd2,
        ST_LIMIT_SET = 2'd3
    } status_t;

    // Commands from the sequencer to the ring
    typedef struct packed {
        logic rd_req;   // read the size of the oldest entry
        logic pop;      // drop the oldest entry
        logic push;     // insert a new entry as newest
    } ring_cmd_t;

    // Ring status back to the sequencer
    typedef struct packed {
        logic       empty;
        logic       full;
        logic [6:0] entry_count;
    } ring_stat_t;

endpackage

/* hw/rtl/htr_req_if.sv */
`timescale 1ns / 1ps

interface htr_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] entry_size;
    logic [31:0] new_limit;

    modport source (output valid, output mode, output entry_size, output new_limit,
                    input ready);
    modport sink   (input valid, input mode, input entry_size, input new_limit,
                    output ready);
endinterface

/* hw/rtl/htr_rsp_if.sv */
`timescale 1ns / 1ps

interface htr_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  evicted_count;
    logic [31:0] bytes_held;
    logic [6:0]  entry_count;

    modport source (output valid, output status, output evicted_count,
                    output bytes_held, output entry_count, input ready);
    modport sink   (input valid, input status, input evicted_count,
                    input bytes_held, input entry_count, output ready);
endinterface

/* hw/rtl/htr_ring.sv */
`timescale 1ns / 1ps

module htr_ring #(
    parameter int SLOTS = htr_pkg::SLOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  htr_pkg::ring_cmd_t  cmd,
    input  logic [31:0]         wr_size,
    output logic [31:0]         rd_size,
    output htr_pkg::ring_stat_t stat
);
    import htr_pkg::*;

    localparam int IW = $clog2(SLOTS);

    logic [31:0]   entry_mem [SLOTS];
    logic [31:0]   rd_size_reg;
    logic [IW-1:0] newest_reg;
    logic [IW-1:0] oldest_reg;
    logic [IW-1:0] count_reg;
    logic [IW-1:0] newest_dec;
    logic [IW-1:0] oldest_dec;

    // Step a slot index down with wrap
    function automatic logic [IW-1:0] slot_dec(input logic [IW-1:0] s);
        logic [IW-1:0] r;
        if (s == '0)
            r = IW'(SLOTS - 1);
        else
            r = s - IW'(1);
        return r;
    endfunction

    assign newest_dec = slot_dec(newest_reg);
    assign oldest_dec = slot_dec(oldest_reg);

    // Size store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            entry_mem[newest_dec] <= wr_size;
        end
        if (cmd.rd_req)
        begin
            rd_size_reg <= entry_mem[oldest_dec];
        end
    end

    // Ring pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg <= '0;
            oldest_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                newest_reg <= newest_dec;
            end
            if (cmd.pop)
            begin
                oldest_reg <= oldest_dec;
            end
            if (cmd.push && !cmd.pop)
                count_reg <= count_reg + IW'(1);
            else if (cmd.pop && !cmd.push)
                count_reg <= count_reg - IW'(1);
        end
    end

    assign rd_size          = rd_size_reg;
    assign stat.empty       = (count_reg == '0);
    assign stat.full        = (count_reg == IW'(SLOTS - 1));
    assign stat.entry_count = 7'(count_reg);

endmodule

/* hw/rtl/header_table_ring_with_eviction_unit.sv */
`timescale 1ns / 1ps

// Size-bounded header table ring (HPACK-style dynamic table, sizes only). Each
// request beat on req (mode 0 adds an entry of entry_size bytes, mode 1 sets a
// new byte limit) yields one result beat on rsp with status, entries evicted,
// bytes held and entry count. Eviction walks the oldest entries one at a time,
// reading each size (S_EVAL) and then dropping it (S_DROP), through the size
// store's single registered read port and a shared subtract/compare unit.
// req.ready is high only while the sequencer is idle; a finished result sits in
// the output register, so the next request is taken while it waits on rsp.
// The table holds up to SLOTS-1 entries; the byte limit resets to 4096.
module header_table_ring_with_eviction_unit #(
    parameter int SLOTS = htr_pkg::SLOTS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    htr_req_if.sink   req,
    htr_rsp_if.source rsp
);
    import htr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DROP,
        S_DONE
    } state_t;

    state_t      state_reg;
    logic        mode_reg;
    logic        all_reg;       // evict everything, regardless of bytes
    logic [31:0] esize_reg;
    logic [31:0] target_reg;
    logic [31:0] limit_reg;
    logic [31:0] held_reg;
    logic [7:0]  evicted_reg;
    status_t     status_reg;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [7:0]  out_evicted_reg;
    logic [31:0] out_bytes_reg;
    logic [6:0]  out_count_reg;

    ring_cmd_t   ring_cmd;
    ring_stat_t  ring_stat;
    logic [31:0] rd_size;
    logic        evict_go;
    logic        out_free;

    htr_ring #(
        .SLOTS (SLOTS)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ring_cmd),
        .wr_size (esize_reg),
        .rd_size (rd_size),
        .stat    (ring_stat)
    );

    // Shared compare: keep evicting while something is held and over target, or while anything is held if all_reg
    assign evict_go = !ring_stat.empty && (all_reg || (held_reg > target_reg));
    assign out_free = !out_valid_reg || rsp.ready;

    // Ring commands from the sequencer
    always_comb
    begin
        ring_cmd        = '0;
        ring_cmd.rd_req = (state_reg == S_EVAL) && evict_go;
        ring_cmd.pop    = (state_reg == S_DROP);
        ring_cmd.push   = (state_reg == S_EVAL) && !evict_go && !mode_reg
                          && !all_reg && !ring_stat.full;
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            limit_reg       <= RESET_LIMIT;
            held_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= '0;
            out_evicted_reg <= '0;
            out_bytes_reg   <= '0;
            out_count_reg   <= '0;
            mode_reg        <= 1'b0;
            all_reg         <= 1'b0;
            esize_reg       <= '0;
            target_reg      <= '0;
            evicted_reg     <= '0;
            status_reg      <= ST_ADDED;
        end
        else
        begin
            // Taken result beat leaves, unless a new one is loaded below
            if (out_valid_reg && rsp.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        mode_reg    <= req.mode;
                        esize_reg   <= req.entry_size;
                        evicted_reg <= '0;
                        all_reg     <= 1'b0;
                        if (req.mode)
                        begin
                            limit_reg  <= req.new_limit;
                            target_reg <= req.new_limit;
                            status_reg <= ST_LIMIT_SET;
                        end
                        else if (req.entry_size > limit_reg)
                        begin
                            all_reg    <= 1'b1;
                            status_reg <= ST_TOO_LARGE;
                        end
                        else
                        begin
                            target_reg <= limit_reg - req.entry_size;
                        end
                        state_reg <= S_EVAL;
                    end
                end

                S_EVAL:
                begin
                    if (evict_go)
                    begin
                        state_reg <= S_DROP;
                    end
                    else
                    begin
                        if (all_reg)
                        begin
                            held_reg <= '0;
                        end
                        else if (!mode_reg)
                        begin
                            if (ring_stat.full)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                held_reg   <= held_reg + esize_reg;
                                status_reg <= ST_ADDED;
                            end
                        end
                        state_reg <= S_DONE;
                    end
                end

                S_DROP:
                begin
                    // rd_size holds the oldest entry's size
                    held_reg    <= held_reg - rd_size;
                    evicted_reg <= evicted_reg + 8'd1;
                    state_reg   <= S_EVAL;
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_status_reg  <= status_reg;
                        out_evicted_reg <= evicted_reg;
                        out_bytes_reg   <= held_reg;
                        out_count_reg   <= ring_stat.entry_count;
                        state_reg       <= S_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.evicted_count = out_evicted_reg;
    assign rsp.bytes_held    = out_bytes_reg;
    assign rsp.entry_count   = out_count_reg;

endmodule

/* hw/rtl/htr_checker.sv */
`timescale 1ns / 1ps

module htr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [7:0]  rsp_evicted_count,
    input logic [31:0] rsp_bytes_held,
    input logic [6:0]  rsp_entry_count
);
    import htr_pkg::*;

    // One request at a time: ready drops right after a request beat
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("req.ready high the cycle after a request beat");

    // An oversized entry leaves the table empty
    a_too_large_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_TOO_LARGE))
            |-> ((rsp_bytes_held == '0) && (rsp_entry_count == '0)))
        else $error("oversized entry left entries or bytes behind");

    // A stored entry means the table holds at least one entry
    a_added_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_ADDED)) |-> (rsp_entry_count != '0))
        else $error("entry reported added but table is empty");

    // A stalled result beat holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
            && $stable(rsp_evicted_count) && $stable(rsp_bytes_held)
            && $stable(rsp_entry_count)))
        else $error("result beat changed while stalled");

endmodule

bind header_table_ring_with_eviction_unit htr_checker u_htr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_evicted_count (rsp.evicted_count),
    .rsp_bytes_held    (rsp.bytes_held),
    .rsp_entry_count   (rsp.entry_count)
);

/* sim/header_table_ring_with_eviction_unit_tb.sv */
`timescale 1ns / 1ps

module header_table_ring_with_eviction_unit_tb;

    import htr_pkg::*;

    localparam int RING_SLOTS = SLOTS_DEFAULT;
    localparam int RANDOM_REQUESTS = 1500;

    // Request modes
    localparam logic MODE_ADD       = 1'b0;
    localparam logic MODE_SET_LIMIT = 1'b1;

    typedef struct packed {
        status_t     status;
        logic [7:0]  evicted;
        logic [31:0] bytes;
        logic [6:0]  count;
    } table_result_t;

    // One directed request; the result is typed in only when known_result is set
    typedef struct packed {
        logic          known_result;
        logic          mode;
        logic [31:0]   esize;
        logic [31:0]   nlim;
        table_result_t result;
    } directed_req_t;

    localparam int DIRECTED_ROWS = 24;

    logic clk;
    logic rst_n;

    htr_req_if req_bus ();
    htr_rsp_if rsp_bus ();

    header_table_ring_with_eviction_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow of the table: held sizes, oldest at the front
    logic [31:0]   tbl_sizes[$];
    logic [31:0]   tbl_bytes;
    logic [31:0]   tbl_limit;

    table_result_t pending_results[$];
    directed_req_t directed_reqs [DIRECTED_ROWS];

    int unsigned   burst_left;
    int unsigned   requests_sent;
    int unsigned   results_seen;
    int unsigned   errors;
    int unsigned   status_count [4];
    int unsigned   max_evicted;
    table_result_t got_want;

    // Receiver stall pattern state
    int unsigned   ready_style;
    int unsigned   ready_phase_left;
    int unsigned   stall_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Drop oldest entries while the byte total is above target
    function automatic logic [7:0] evict_down_to(input logic [31:0] target);
        logic [7:0] n;
        n = '0;
        while (tbl_bytes > target && tbl_sizes.size() > 0) begin
            tbl_bytes = tbl_bytes - tbl_sizes.pop_front();
            n++;
        end
        return n;
    endfunction

    // Apply one request to the shadow table and return its result
    function automatic table_result_t apply_request(input logic mode,
                                                    input logic [31:0] esize,
                                                    input logic [31:0] nlim);
        table_result_t r;
        r.evicted = '0;
        if (mode == MODE_SET_LIMIT) begin
            tbl_limit = nlim;
            r.evicted = evict_down_to(nlim);
            r.status  = ST_LIMIT_SET;
        end
        else if (esize > tbl_limit) begin
            // too large: table is emptied, zero-size entries too
            r.evicted = 8'(tbl_sizes.size());
            tbl_sizes.delete();
            tbl_bytes = '0;
            r.status  = ST_TOO_LARGE;
        end
        else begin
            r.evicted = evict_down_to(tbl_limit - esize);
            if (tbl_sizes.size() >= RING_SLOTS - 1) begin
                r.status = ST_FULL;
            end
            else begin
                tbl_sizes.push_back(esize);
                tbl_bytes = tbl_bytes + esize;
                r.status  = ST_ADDED;
            end
        end
        r.bytes = tbl_bytes;
        r.count = 7'(tbl_sizes.size());
        return r;
    endfunction

    // Entry size around the current limit: zero, exact fit, just over, anything, or small
    function automatic logic [31:0] pick_size(input logic [31:0] lim);
        logic [31:0] s;
        case ($urandom_range(0, 9))
            0: s = '0;
            1: s = lim;
            2: s = (lim == 32'hFFFF_FFFF) ? $urandom : lim + 32'd1;
            3: s = $urandom;
            default: s = $urandom_range(0, lim / 4 + 1);
        endcase
        return s;
    endfunction

    // Drive one request beat; called and returns at a falling edge
    task automatic send_request(input logic mode, input logic [31:0] esize,
                                input logic [31:0] nlim, input logic known_result,
                                input table_result_t typed_result);
        table_result_t predicted;
        if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 60);
        end
        req_bus.valid      <= 1'b1;
        req_bus.mode       <= mode;
        req_bus.entry_size <= esize;
        req_bus.new_limit  <= nlim;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        predicted = apply_request(mode, esize, nlim);
        pending_results.push_back(known_result ? typed_result : predicted);
        burst_left--;
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_predicted(input logic mode, input logic [31:0] esize,
                                  input logic [31:0] nlim);
        send_request(mode, esize, nlim, 1'b0, '0);
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
                 $time, field, want, want, got, got);
        errors++;
    endtask

    // Receiver: phases of no stalls, random stalls, long stalls, rare stalls
    always @(negedge clk) begin
        if (ready_phase_left == 0) begin
            ready_style      = $urandom_range(0, 3);
            ready_phase_left = $urandom_range(20, 300);
        end
        ready_phase_left--;
        case (ready_style)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2:
            begin
                if (stall_left > 0) begin
                    stall_left--;
                    rsp_bus.ready <= 1'b0;
                end
                else begin
                    rsp_bus.ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        stall_left = $urandom_range(1, 12);
                end
            end
            default: rsp_bus.ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // Result checker
    always @(posedge clk) begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected (status %0d, bytes %0d)",
                         $time, rsp_bus.status, rsp_bus.bytes_held);
                errors++;
            end
            else begin
                got_want = pending_results.pop_front();
                if (rsp_bus.status !== got_want.status)
                    report_field("status", 32'(got_want.status), 32'(rsp_bus.status));
                if (rsp_bus.evicted_count !== got_want.evicted)
                    report_field("evicted_count", 32'(got_want.evicted),
                                 32'(rsp_bus.evicted_count));
                if (rsp_bus.bytes_held !== got_want.bytes)
                    report_field("bytes_held", got_want.bytes, rsp_bus.bytes_held);
                if (rsp_bus.entry_count !== got_want.count)
                    report_field("entry_count", 32'(got_want.count),
                                 32'(rsp_bus.entry_count));
            end
            if (!$isunknown(rsp_bus.status))
                status_count[rsp_bus.status]++;
            if (!$isunknown(rsp_bus.evicted_count) && rsp_bus.evicted_count > max_evicted)
                max_evicted = rsp_bus.evicted_count;
        end
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("Timeout with %0d results still outstanding", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // Main stimulus
    initial begin
        rst_n              = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.mode       = MODE_ADD;
        req_bus.entry_size = '0;
        req_bus.new_limit  = '0;
        rsp_bus.ready      = 1'b0;
        tbl_bytes          = '0;
        tbl_limit          = RESET_LIMIT;
        burst_left         = 0;
        requests_sent      = 0;
        results_seen       = 0;
        errors             = 0;
        max_evicted        = 0;
        ready_style        = 0;
        ready_phase_left   = 0;
        stall_left         = 0;
        foreach (status_count[i]) status_count[i] = 0;

        directed_reqs = '{
            // empty table after reset, zero-size entry
            '{1'b1, MODE_ADD, 32'd0, 32'd0, '{ST_ADDED, 8'd0, 32'd0, 7'd1}},
            // entry equal to the limit; zero-size entry stays
            '{1'b0, MODE_ADD, 32'd4096, 32'd0, '0},
            // just over the limit: everything goes
            '{1'b1, MODE_ADD, 32'd4097, 32'd0, '{ST_TOO_LARGE, 8'd2, 32'd0, 7'd0}},
            '{1'b1, MODE_ADD, 32'hFFFF_FFFF, 32'd0, '{ST_TOO_LARGE, 8'd0, 32'd0, 7'd0}},
            // limit of zero; entry_size ignored here
            '{1'b1, MODE_SET_LIMIT, 32'hFFFF_FFFF, 32'd0,
              '{ST_LIMIT_SET, 8'd0, 32'd0, 7'd0}},
            '{1'b1, MODE_ADD, 32'd0, 32'hFFFF_FFFF, '{ST_ADDED, 8'd0, 32'd0, 7'd1}},
            '{1'b0, MODE_ADD, 32'd0, 32'd0, '0},
            // too large evicts the zero-size entries as well
            '{1'b1, MODE_ADD, 32'd1, 32'd0, '{ST_TOO_LARGE, 8'd2, 32'd0, 7'd0}},
            // widest limit and widest entry
            '{1'b1, MODE_SET_LIMIT, 32'd0, 32'hFFFF_FFFF,
              '{ST_LIMIT_SET, 8'd0, 32'd0, 7'd0}},
            '{1'b1, MODE_ADD, 32'hFFFF_FFFF, 32'd0,
              '{ST_ADDED, 8'd0, 32'hFFFF_FFFF, 7'd1}},
            '{1'b0, MODE_ADD, 32'hFFFF_FFFF, 32'd0, '0},
            '{1'b0, MODE_ADD, 32'd0, 32'd0, '0},
            // shrinking limit leaves the newer zero-size entry
            '{1'b0, MODE_SET_LIMIT, 32'd0, 32'h7FFF_FFFF, '0},
            '{1'b0, MODE_SET_LIMIT, 32'd0, 32'd100, '0},
            '{1'b0, MODE_ADD, 32'd60, 32'd0, '0},
            '{1'b0, MODE_ADD, 32'd40, 32'd0, '0},
            // partial eviction by bytes
            '{1'b0, MODE_ADD, 32'd50, 32'd0, '0},
            '{1'b0, MODE_SET_LIMIT, 32'd0, 32'd45, '0},
            '{1'b0, MODE_SET_LIMIT, 32'h5A5A_5A5A, 32'd4096, '0},
            '{1'b0, MODE_ADD, 32'd1000, 32'hA5A5_A5A5, '0},
            '{1'b1, MODE_ADD, 32'h8000_0000, 32'd0, '{ST_TOO_LARGE, 8'd1, 32'd0, 7'd0}},
            '{1'b1, MODE_SET_LIMIT, 32'h5555_5555, 32'hAAAA_AAAA,
              '{ST_LIMIT_SET, 8'd0, 32'd0, 7'd0}},
            '{1'b1, MODE_ADD, 32'hAAAA_AAAA, 32'h5555_5555,
              '{ST_ADDED, 8'd0, 32'hAAAA_AAAA, 7'd1}},
            '{1'b1, MODE_SET_LIMIT, 32'd0, 32'd0, '{ST_LIMIT_SET, 8'd1, 32'd0, 7'd0}}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        foreach (directed_reqs[i])
            send_request(directed_reqs[i].mode, directed_reqs[i].esize,
                         directed_reqs[i].nlim, directed_reqs[i].known_result,
                         directed_reqs[i].result);

        // Random scenarios
        while (requests_sent < DIRECTED_ROWS + RANDOM_REQUESTS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    // churn of adds around a modest limit
                    if ($urandom_range(0, 1))
                        send_predicted(MODE_SET_LIMIT, $urandom, $urandom_range(0, 16384));
                    repeat ($urandom_range(5, 30)) begin
                        if ($urandom_range(0, 5) == 0)
                            send_predicted(MODE_SET_LIMIT, $urandom,
                                           $urandom_range(0, 16384));
                        else
                            send_predicted(MODE_ADD, pick_size(tbl_limit), $urandom);
                    end
                end
                5:
                begin
                    // fill the ring with small entries, run into the slot limit
                    send_predicted(MODE_SET_LIMIT, $urandom,
                                   $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                                        : ($urandom | 32'h8000_0000));
                    repeat ($urandom_range(118, 140))
                        send_predicted(MODE_ADD,
                                       ($urandom_range(0, 3) == 0) ? 32'd0
                                                                   : $urandom_range(0, 64),
                                       $urandom);
                    // then drain it, or shrink it to a small limit, in one request
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            send_predicted(MODE_SET_LIMIT, $urandom, 32'd0);
                            send_predicted(MODE_ADD, 32'd1, $urandom);
                        end
                        1: send_predicted(MODE_SET_LIMIT, $urandom, $urandom_range(0, 512));
                        default:
                        begin
                            send_predicted(MODE_SET_LIMIT, $urandom, 32'hFFFF_FFFE);
                            send_predicted(MODE_ADD, 32'hFFFF_FFFF, $urandom);
                        end
                    endcase
                end
                6, 7:
                begin
                    // unconstrained requests
                    repeat ($urandom_range(5, 20))
                        send_predicted(1'($urandom_range(0, 1)), $urandom, $urandom);
                end
                default:
                begin
                    // limit extremes followed by adds near the limit
                    case ($urandom_range(0, 6))
                        0: send_predicted(MODE_SET_LIMIT, $urandom, 32'd0);
                        1: send_predicted(MODE_SET_LIMIT, $urandom, 32'd1);
                        2: send_predicted(MODE_SET_LIMIT, $urandom, RESET_LIMIT);
                        3: send_predicted(MODE_SET_LIMIT, $urandom, 32'hFFFF_FFFE);
                        4: send_predicted(MODE_SET_LIMIT, $urandom, 32'hFFFF_FFFF);
                        5: send_predicted(MODE_SET_LIMIT, $urandom, $urandom_range(0, 256));
                        default: send_predicted(MODE_SET_LIMIT, $urandom, $urandom);
                    endcase
                    repeat ($urandom_range(3, 8))
                        send_predicted(MODE_ADD, pick_size(tbl_limit), $urandom);
                end
            endcase
        end
        req_bus.valid <= 1'b0;

        // Drain, then watch for stray beats
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d requests, %0d results: added %0d, too large %0d, full %0d, limit set %0d",
                 requests_sent, results_seen, status_count[ST_ADDED],
                 status_count[ST_TOO_LARGE], status_count[ST_FULL],
                 status_count[ST_LIMIT_SET]);
        $display("Largest eviction in one request: %0d entries, mismatches: %0d",
                 max_evicted, errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
